FILE: sv/lru_recency_list_macros.svh
// ----------------------------------------------------------------------------
// LRU recency list assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_RECENCY_LIST_MACROS_SVH
`define LRU_RECENCY_LIST_MACROS_SVH

// Same-cycle implication.
`define LRL_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lrl_pkg.sv
// ----------------------------------------------------------------------------
// LRU recency list package
// Field widths, opcodes and the control struct shared by the cells.
// ----------------------------------------------------------------------------
package lrl_pkg;

  localparam int KEY_W = 32;
  localparam int OP_W  = 2;
  localparam int OCC_W = 5;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_USE    = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic push;  // shift toward the rear, new key enters at the front
    logic pull;  // close the gap left by the front-most match
  } lrl_ctl_t;

endpackage

FILE: sv/lru_recency_list.sv
// ----------------------------------------------------------------------------
// LRU recency list
// Recency-ordered key list built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Result: registered when the item is accepted; a use of a key that hits drops
//   each copy in turn, then pushes the key, and only then registers its result.
// Throughput: insert, remove and find take one item per cycle unless a use is
//   running or the result slot is held; all cells match and shift once per cycle.
// Reset: synchronous, active low; empties the list, capacity back to 16.
`include "lru_recency_list_macros.svh"

module lru_recency_list
  import lrl_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  // cfg: capacity_limit
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  // in_tdata: [1:0] opcode, [33:2] key, [39:34] zero
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [39:0]      in_tdata,
  // out_tdata: [0] flag, [5:1] occupancy, [7:6] zero
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic             busy_r, busy_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_flag_r, out_flag_nxt;
  logic [OCC_W-1:0] out_occ_r;

  logic [OP_W-1:0]  in_op;
  logic [KEY_W-1:0] in_key;
  logic [KEY_W-1:0] cmp_key;
  logic             fire;
  logic             any_match;
  logic             evict;
  logic [MW-1:0]    eff_cap;
  logic [MW-1:0]    cap_ext;
  lrl_ctl_t         ctl;

  logic [DEPTH:0]   seen;
  logic [DEPTH-1:0] valid;
  logic [KEY_W-1:0] entries [DEPTH];

  assign in_op  = in_tdata[1:0];
  assign in_key = in_tdata[33:2];

  // Take an item only between use sequences and with the result slot free.
  assign in_tready = !busy_r && (!out_valid_r || out_tready);
  assign fire      = in_tvalid && in_tready;

  // Mid-use, keep comparing against the latched key.
  assign cmp_key = busy_r ? key_r : in_key;

  // Clamp capacity to 1..DEPTH.
  assign cap_ext = MW'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = MW'(1);
    end else if (cap_ext > MW'(DEPTH)) begin
      eff_cap = MW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign evict = MW'(count_r) >= eff_cap;

  // The cell chain: slot 0 is the front.
  assign seen[0] = 1'b0;
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign valid[i] = CW'(i) < count_r;
      lrl_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .cmp_key (cmp_key),
        .valid_i (valid[i]),
        .left_i  ((i == 0) ? cmp_key : entries[(i == 0) ? 0 : i - 1]),
        .right_i (entries[(i == DEPTH - 1) ? i : i + 1]),
        .seen_i  (seen[i]),
        .seen_o  (seen[i+1]),
        .entry_o (entries[i])
      );
    end
  endgenerate
  assign any_match = seen[DEPTH];

  // Sequencer: insert, remove, find and a missed use finish at accept; a use that
  // hits drops one copy per cycle, then pushes the key to the front.
  always_comb begin
    ctl           = '0;
    count_nxt     = count_r;
    busy_nxt      = busy_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_flag_nxt  = out_flag_r;
    if (busy_r) begin
      if (any_match) begin
        ctl.pull  = 1'b1;
        count_nxt = count_r - CW'(1);
      end else begin
        ctl.push      = 1'b1;
        count_nxt     = count_r + CW'(1);
        busy_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
        out_flag_nxt  = 1'b1;
      end
    end else if (fire) begin
      out_valid_nxt = 1'b1;
      out_flag_nxt  = any_match;
      case (in_op)
        OP_INSERT: begin
          ctl.push     = 1'b1;
          out_flag_nxt = evict;
          if (!evict) begin
            count_nxt = count_r + CW'(1);
          end
        end
        OP_REMOVE: begin
          if (any_match) begin
            ctl.pull  = 1'b1;
            count_nxt = count_r - CW'(1);
          end
        end
        OP_USE: begin
          if (any_match) begin
            // Hold the result until the key sits at the front.
            ctl.pull      = 1'b1;
            count_nxt     = count_r - CW'(1);
            busy_nxt      = 1'b1;
            key_nxt       = in_key;
            out_valid_nxt = 1'b0;
          end
        end
        OP_FIND: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    out_flag_r <= out_flag_nxt;
    out_occ_r  <= OCC_W'(count_nxt);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_occ_r, out_flag_r};

  `LRL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "occupancy above depth")
  `LRL_ASSERT_NOW(a_ctl_excl, ctl.push, !ctl.pull, "push and pull together")
  `LRL_ASSERT_NOW(a_busy_stall, busy_r, !in_tready && !out_valid_r, "item taken mid-use")
  `LRL_ASSERT_NEXT(a_insert_grow, fire && in_op == OP_INSERT && !evict,
    count_r == $past(count_r) + CW'(1), "insert without eviction did not grow list")

endmodule

FILE: sv/lrl_cell.sv
// ----------------------------------------------------------------------------
// LRU recency list cell
// One list slot: holds a key, compares it and shifts with its neighbors.
// ----------------------------------------------------------------------------
module lrl_cell
  import lrl_pkg::*;
(
  input  logic             clk,
  input  lrl_ctl_t         ctl,
  input  logic [KEY_W-1:0] cmp_key,
  input  logic             valid_i,
  input  logic [KEY_W-1:0] left_i,
  input  logic [KEY_W-1:0] right_i,
  input  logic             seen_i,
  output logic             seen_o,
  output logic [KEY_W-1:0] entry_o
);

  logic [KEY_W-1:0] entry_r;
  logic [KEY_W-1:0] entry_nxt;
  logic             match;

  assign match  = valid_i && (entry_r == cmp_key);
  assign seen_o = seen_i | match;

  always_comb begin
    if (ctl.push) begin
      entry_nxt = left_i;
    end else if (ctl.pull && seen_o) begin
      entry_nxt = right_i;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;

endmodule

FILE: tb/lru_recency_list_tb.sv
// ----------------------------------------------------------------------------
// LRU recency list testbench
// Streams insert, remove, use and find items into the recency list under
// random handshake gaps. It mirrors the list contents and the capacity
// register to work out each flag and occupancy, and checks every result in
// order. A directed table comes first, then random phases across capacities.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lru_recency_list_tb;
  import lrl_pkg::*;

  localparam int DEPTH           = 16;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int POOL_SIZE       = 6;
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES   = 24;    // idle wait after the results drain
  localparam int QUIET_LIMIT     = 3000;  // cycles without a handshake on either channel
  localparam int MAX_PRINTS      = 60;

  typedef struct {
    logic             flag;
    logic [OCC_W-1:0] occ;
  } list_result_t;

  // One row of the directed table: a capacity write or one item, with the
  // result typed in where it is obvious.
  typedef struct {
    bit               is_cfg;
    logic [CAP_W-1:0] cap;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    bit               known;
    logic             flag;
    logic [OCC_W-1:0] occ;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [39:0]      in_tdata;   // [1:0] opcode, [33:2] key, [39:34] zero
  logic             out_tvalid;
  logic             out_tready;
  logic [7:0]       out_tdata;  // [0] flag, [5:1] occupancy, [7:6] zero

  // Typed-in expectation that travels alongside the offered item.
  bit               row_known;
  logic             row_flag;
  logic [OCC_W-1:0] row_occ;

  // Mirror of the list: slot 0 is the front.
  logic [KEY_W-1:0] list_keys [DEPTH];
  int               list_count;
  logic [CAP_W-1:0] cap_reg;

  list_result_t     pending_results[$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               mismatches;
  int               quiet_cycles;
  bit               idle_on;
  int               hold_requests;
  int               hold_served;

  // Capacity 1 below occupancy, then 0 (acts as 1), then 31 (acts as 16).
  stim_row_t dir_rows [24] = '{
    '{1'b0, 5'd0,  OP_FIND,   32'h0000_0000, 1'b1, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_REMOVE, 32'h0000_0000, 1'b1, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_USE,    32'h0000_0000, 1'b1, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0000, 1'b1, 1'b0, 5'd1},
    '{1'b0, 5'd0,  OP_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, 5'd2},
    '{1'b0, 5'd0,  OP_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, 5'd3},
    '{1'b0, 5'd0,  OP_FIND,   32'hFFFF_FFFF, 1'b1, 1'b1, 5'd3},
    '{1'b0, 5'd0,  OP_USE,    32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0000, 1'b0, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_REMOVE, 32'h0000_0000, 1'b0, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_FIND,   32'h0000_0000, 1'b0, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_REMOVE, 32'h1234_5678, 1'b1, 1'b0, 5'd2},
    '{1'b1, 5'd1,  OP_INSERT, 32'h0000_0000, 1'b0, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_INSERT, 32'h5A5A_5A5A, 1'b0, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_INSERT, 32'hA5A5_A5A5, 1'b0, 1'b0, 5'd0},
    '{1'b1, 5'd0,  OP_INSERT, 32'h0000_0000, 1'b0, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0001, 1'b0, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_REMOVE, 32'h0000_0001, 1'b0, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0002, 1'b0, 1'b0, 5'd0},
    '{1'b1, 5'd31, OP_INSERT, 32'h0000_0000, 1'b0, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_USE,    32'h0000_0002, 1'b0, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_INSERT, 32'h8000_0000, 1'b0, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_FIND,   32'h7FFF_FFFF, 1'b0, 1'b0, 5'd0},
    '{1'b0, 5'd0,  OP_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0}
  };

  // Capacity per random phase: reset value, extremes, above depth, a few in between.
  logic [CAP_W-1:0] phase_caps [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd17, 5'd4,
                                            5'd31, 5'd2, 5'd12, 5'd9, 5'd16};

  lru_recency_list #(
    .DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // List mirror
  // ---------------------------------------------------------------------------

  function automatic int front_match(input logic [KEY_W-1:0] key);
    for (int i = 0; i < list_count; i++)
      if (list_keys[i] == key) return i;
    return -1;
  endfunction

  // Shift every entry one slot to the rear and place the key at the front.
  function automatic void push_front(input logic [KEY_W-1:0] key);
    for (int i = list_count; i > 0; i--)
      list_keys[i] = list_keys[i - 1];
    list_keys[0] = key;
    list_count++;
  endfunction

  // Apply one operation to the mirror and return its flag and occupancy.
  function automatic void recency_step(input logic [OP_W-1:0] op,
                                       input logic [KEY_W-1:0] key,
                                       output logic flag,
                                       output logic [OCC_W-1:0] occ);
    int lim;
    int pos;
    int w;
    flag = 1'b0;
    lim  = cap_reg;
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    case (op)
      OP_INSERT: begin
        // A full list (or one over a lowered capacity) loses exactly one rear entry.
        if (list_count >= lim) begin
          if (list_count > 0) list_count--;
          flag = 1'b1;
        end
        push_front(key);
      end
      OP_REMOVE: begin
        pos = front_match(key);
        if (pos >= 0) begin
          for (int i = pos; i + 1 < list_count; i++)
            list_keys[i] = list_keys[i + 1];
          list_count--;
          flag = 1'b1;
        end
      end
      OP_USE: begin
        // Drop every copy, then put one back at the front.
        if (front_match(key) >= 0) begin
          w = 0;
          for (int r = 0; r < list_count; r++)
            if (list_keys[r] != key) begin
              list_keys[w] = list_keys[r];
              w++;
            end
          list_count = w;
          push_front(key);
          flag = 1'b1;
        end
      end
      default: begin
        flag = (front_match(key) >= 0);
      end
    endcase
    occ = list_count[OCC_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTS)
      $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: sample both channels and the config port at each rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    list_result_t got;
    list_result_t want;
    logic         p_flag;
    logic [OCC_W-1:0] p_occ;
    if (rst_n) begin
      if (cfg_wr_en) cap_reg = cfg_wr_data;
      // Check the oldest expectation first; a result can never belong to an
      // item accepted at the same edge.
      if (out_tvalid && out_tready) begin
        got.flag = out_tdata[0];
        got.occ  = out_tdata[5:1];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, occupancy", got.occ, -1);
        end else begin
          want = pending_results.pop_front();
          if (got.flag !== want.flag) report_mismatch("flag", got.flag, want.flag);
          if (got.occ !== want.occ) report_mismatch("occupancy", got.occ, want.occ);
        end
      end
      if (in_tvalid && in_tready) begin
        recency_step(in_tdata[1:0], in_tdata[33:2], p_flag, p_occ);
        if (row_known) begin
          want.flag = row_flag;
          want.occ  = row_occ;
        end else begin
          want.flag = p_flag;
          want.occ  = p_occ;
        end
        pending_results.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if nothing moves on either channel for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("lru_recency_list_tb failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_requests != hold_served) begin
        // Hold off long enough for the block to fill and drop in_tready.
        hold_served = hold_requests;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until the edge that accepts it.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input bit known, input logic eflag,
                           input logic [OCC_W-1:0] eocc);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, key, op};
    row_known <= known;
    row_flag  <= eflag;
    row_occ   <= eocc;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the capacity only once the block has gone idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly keys from a small pool so hits, duplicates and evictions happen,
  // with some fully random keys that almost always miss.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_INSERT;
    if (r < 55) return OP_REMOVE;
    if (r < 75) return OP_USE;
    return OP_FIND;
  endfunction

  initial begin
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    row_known     <= 1'b0;
    row_flag      <= 1'b0;
    row_occ       <= '0;
    list_count    = 0;
    cap_reg       = CAP_RESET;
    mismatches    = 0;
    hold_requests = 0;
    hold_served   = 0;
    idle_on       = 1'b1;
    foreach (list_keys[i]) list_keys[i] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: empty list, extremes, duplicates, missing keys and
    // every capacity corner.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_capacity(dir_rows[i].cap);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].known,
                  dir_rows[i].flag, dir_rows[i].occ);
      end
    end

    // Random phases, one capacity each; every third phase and the last one
    // run without idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_caps[ph]);
      foreach (key_pool[k]) key_pool[k] = $urandom;
      idle_on = (ph != PHASES - 1) && (ph % 3 != 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Ask the receiver for its long hold-off while items keep coming.
        if (ph == 0 && n == 40) hold_requests++;
        // Pause once mid-phase until every result is back.
        if (ph == 4 && n == 75) drain_results();
        if (idle_on && $urandom_range(0, 7) == 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        send_item(pick_op(), pick_key(), 1'b0, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("lru_recency_list_tb passed");
    end else begin
      $display("lru_recency_list_tb failed");
    end
    $finish;
  end

endmodule
